@@ rtl/distance_vector_route_update_assert.svh @@
// ----------------------------------------------------------------------------
// Distance-vector route update - assertion macros
// Shorthand for clocked checks with reset masking, same-cycle and next-cycle.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DVRU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define DVRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ rtl/dvru_pkg.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route update - shared package
// Widths, codes and the operation record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package dvru_pkg;

    localparam int NODES       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int EMIT_N      = (NODES < MAX_RESULTS) ? NODES : MAX_RESULTS;
    localparam int IDX_W       = $clog2(NODES);
    localparam int COST_W      = 30;
    localparam int DELAY_W     = 16;
    localparam int NODE_W      = 4;
    localparam int MODE_W      = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [COST_W-1:0] INF_COST = 30'd1000000000;

    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    // Register index taken from paddr[PADDR_W-1].
    localparam logic REG_OWN_ID = 1'b0;

    typedef struct packed {
        logic [MODE_W-1:0] kind;
        logic              dest_ok;
        logic [NODE_W-1:0] dest;
        logic [NODE_W-1:0] hop;
        logic [COST_W-1:0] cost;
        logic              last;
    } op_t;

endpackage

`default_nettype wire

@@ rtl/dvru_if.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route update - channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dvru_in_if;
    logic                        valid;
    logic                        ready;
    logic [dvru_pkg::MODE_W-1:0]  mode;
    logic [dvru_pkg::NODE_W-1:0]  neighbor_node;
    logic [dvru_pkg::DELAY_W-1:0] link_delay;
    logic [dvru_pkg::NODE_W-1:0]  dest_index;
    logic [dvru_pkg::COST_W-1:0]  entry_cost;
    logic                        last_entry;

    modport source (output valid, mode, neighbor_node, link_delay, dest_index,
                    entry_cost, last_entry, input ready);
    modport sink (input valid, mode, neighbor_node, link_delay, dest_index,
                  entry_cost, last_entry, output ready);
endinterface

interface dvru_out_if;
    logic                       valid;
    logic                       ready;
    logic [dvru_pkg::NODE_W-1:0] out_dest;
    logic [dvru_pkg::COST_W-1:0] out_cost;
    logic [dvru_pkg::NODE_W-1:0] out_hop;
    logic [dvru_pkg::NODE_W-1:0] source_id;
    logic                       table_changed;
    logic                       out_last;

    modport source (output valid, out_dest, out_cost, out_hop, source_id,
                    table_changed, out_last, input ready);
    modport sink (input valid, out_dest, out_cost, out_hop, source_id,
                  table_changed, out_last, output ready);
endinterface

`default_nettype wire

@@ rtl/dvru_front.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route update - front stage
// Accepts input beats, clips costs, forms the saturating sum and classifies.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_front (
    input  logic           clk,
    input  logic           rst_n,
    dvru_in_if.sink        in_ch,
    output dvru_pkg::op_t  push_op,
    output logic           push_valid,
    input  logic           push_ready
);
    import dvru_pkg::*;

    logic                stage_valid_reg;
    logic                stage_valid_next;
    op_t                 stage_op_reg;
    op_t                 op_next;
    logic [COST_W-1:0]   cost_clip;
    logic [COST_W:0]     sum_wide;
    logic [COST_W-1:0]   sum_clip;
    logic                take;
    logic                keep;

    always_comb
    begin
        cost_clip = (in_ch.entry_cost > INF_COST) ? INF_COST : in_ch.entry_cost;
        sum_wide  = {1'b0, cost_clip} + (COST_W+1)'(in_ch.link_delay);
        sum_clip  = (sum_wide > {1'b0, INF_COST}) ? INF_COST : sum_wide[COST_W-1:0];

        op_next.kind    = in_ch.mode;
        op_next.dest_ok = (int'(in_ch.dest_index) < NODES);
        op_next.dest    = in_ch.dest_index;
        op_next.hop     = in_ch.neighbor_node;
        op_next.cost    = (in_ch.mode == MODE_ADV) ? sum_clip : cost_clip;
        op_next.last    = in_ch.last_entry;
    end

    // The unused mode code is accepted and dropped here.
    assign keep = (in_ch.mode == MODE_LOAD) || (in_ch.mode == MODE_ADV) ||
                  (in_ch.mode == MODE_READ);

    assign in_ch.ready = !stage_valid_reg || push_ready;
    assign take        = in_ch.valid && in_ch.ready;

    assign stage_valid_next = in_ch.ready ? (take && keep) : stage_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_op_reg <= op_next;
        end
    end

    assign push_valid = stage_valid_reg;
    assign push_op    = stage_op_reg;

endmodule

`default_nettype wire

@@ rtl/dvru_fifo.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route update - operation queue
// Short queue of classified operations between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  dvru_pkg::op_t  push_op,
    input  logic           push_valid,
    output logic           push_ready,
    output dvru_pkg::op_t  pop_op,
    output logic           pop_valid,
    input  logic           pop_ready
);
    import dvru_pkg::*;

    op_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_op     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dvru_back.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route update - back part
// Holds the routing table, relaxes entries, and emits reads and table runs.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dvru_pkg::op_t               pop_op,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  logic [dvru_pkg::NODE_W-1:0] own_id,
    dvru_out_if.source                  out_ch
);
    import dvru_pkg::*;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic [COST_W-1:0]  cost_reg [NODES];
    logic [NODE_W-1:0]  hop_reg  [NODES];
    logic               improved_reg;
    logic               improved_next;
    logic               state_reg;
    logic               state_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [NODE_W-1:0]  out_dest_reg;
    logic [NODE_W-1:0]  out_dest_next;
    logic [COST_W-1:0]  out_cost_reg;
    logic [COST_W-1:0]  out_cost_next;
    logic [NODE_W-1:0]  out_hop_reg;
    logic [NODE_W-1:0]  out_hop_next;
    logic               out_changed_reg;
    logic               out_changed_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic               load_out;

    logic               out_free;
    logic               exec;
    logic [IDX_W-1:0]   qidx;
    logic [IDX_W-1:0]   rd_idx;
    logic [COST_W-1:0]  rd_cost;
    logic [NODE_W-1:0]  rd_hop;
    logic               better;
    logic               wr_en;
    logic               emit_end;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign pop_ready = (state_reg == ST_RUN) && out_free;
    assign exec      = pop_valid && pop_ready;

    // One table read port, shared between the queued operation and the run.
    assign qidx    = IDX_W'(pop_op.dest);
    assign rd_idx  = (state_reg == ST_EMIT) ? idx_reg : qidx;
    assign rd_cost = cost_reg[rd_idx];
    assign rd_hop  = hop_reg[rd_idx];

    assign better   = pop_op.dest_ok && (rd_cost > pop_op.cost);
    assign wr_en    = exec && pop_op.dest_ok &&
                      ((pop_op.kind == MODE_LOAD) || ((pop_op.kind == MODE_ADV) && better));
    assign emit_end = (idx_reg == IDX_W'(EMIT_N - 1));

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        improved_next    = improved_reg;
        load_out         = 1'b0;
        out_dest_next    = '0;
        out_cost_next    = '0;
        out_hop_next     = '0;
        out_changed_next = 1'b0;
        out_last_next    = 1'b1;

        unique case (state_reg)
            ST_RUN:
            begin
                if (exec)
                begin
                    unique case (pop_op.kind)
                        MODE_ADV:
                        begin
                            if (better)
                            begin
                                improved_next = 1'b1;
                            end
                            if (pop_op.last)
                            begin
                                if (improved_reg || better)
                                begin
                                    state_next    = ST_EMIT;
                                    idx_next      = '0;
                                    improved_next = 1'b0;
                                end
                                else
                                begin
                                    load_out = 1'b1;
                                end
                            end
                        end
                        MODE_READ:
                        begin
                            load_out      = 1'b1;
                            out_dest_next = pop_op.dest;
                            out_cost_next = pop_op.dest_ok ? rd_cost : INF_COST;
                            out_hop_next  = pop_op.dest_ok ? rd_hop : '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out         = 1'b1;
                    out_dest_next    = NODE_W'(idx_reg);
                    out_cost_next    = rd_cost;
                    out_hop_next     = rd_hop;
                    out_changed_next = 1'b1;
                    out_last_next    = emit_end;
                    idx_next         = idx_reg + 1'b1;
                    if (emit_end)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        out_valid_next = load_out || (out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                cost_reg[i] <= INF_COST;
                hop_reg[i]  <= NODE_W'(i);
            end
            improved_reg  <= 1'b0;
            state_reg     <= ST_RUN;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                cost_reg[qidx] <= pop_op.cost;
                hop_reg[qidx]  <= pop_op.hop;
            end
            improved_reg  <= improved_next;
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_dest_reg    <= out_dest_next;
            out_cost_reg    <= out_cost_next;
            out_hop_reg     <= out_hop_next;
            out_changed_reg <= out_changed_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_dest      = out_dest_reg;
    assign out_ch.out_cost      = out_cost_reg;
    assign out_ch.out_hop       = out_hop_reg;
    assign out_ch.source_id     = own_id;
    assign out_ch.table_changed = out_changed_reg;
    assign out_ch.out_last      = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/distance_vector_route_update.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route update - top level
// One node's Bellman-Ford routing table with load, relax and read items.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  -------   ---------  ----------------------------------------------------
//  in_ch     sink       mode, neighbor_node, link_delay, dest_index,
//                       entry_cost, last_entry
//  out_ch    source     out_dest, out_cost, out_hop, source_id,
//                       table_changed, out_last
//  APB       slave      own_node_id at byte address 0
//
// The back part takes a stream of load, advertised-entry and read beats at
// one per cycle while its result register is free and no table run is under
// way; a beat that gives a result passes the front stage, then the queue
// entry taken by the back, before it reaches the result register.
// A table run follows a last advertised entry whose batch improved the table
// and emits EMIT_N entries in turn through its single read port; no new
// operation leaves the queue during the run, while the front keeps accepting
// until the queue and its stage are full. Reset loads the table at once
// (cost infinity, hop equal to the destination) with no clearing pass.
//
`default_nettype none

module distance_vector_route_update (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dvru_pkg::PADDR_W-1:0]           paddr,
    input  logic [dvru_pkg::PDATA_W-1:0]           pwdata,
    output logic [dvru_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready,
    // Item channels
    dvru_in_if.sink                                in_ch,
    dvru_out_if.source                             out_ch
);
    import dvru_pkg::*;

    logic [NODE_W-1:0] own_id_reg;
    logic [NODE_W-1:0] own_id_next;
    logic              cfg_write;
    logic              reg_sel;

    op_t               push_op;
    logic              push_valid;
    logic              push_ready;
    op_t               pop_op;
    logic              pop_valid;
    logic              pop_ready;

    // ------------------------------------------------------------------
    // Configuration registers. The register index is the word address;
    // writes to any other index are accepted and have no effect.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = paddr[PADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    assign own_id_next = (cfg_write && (reg_sel == REG_OWN_ID)) ?
                         pwdata[NODE_W-1:0] : own_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= '0;
        end
        else
        begin
            own_id_reg <= own_id_next;
        end
    end

    assign prdata = (reg_sel == REG_OWN_ID) ? PDATA_W'(own_id_reg) : '0;

    // ------------------------------------------------------------------
    // Front part: accepts beats, clips the cost at infinity, forms the
    // saturating advertised sum and drops the unused mode.
    // ------------------------------------------------------------------
    dvru_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_op    (push_op),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // ------------------------------------------------------------------
    // Queue between the two parts, so that a table run stalls only the
    // back while the front goes on taking beats.
    // ------------------------------------------------------------------
    dvru_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_op    (push_op),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_op     (pop_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // ------------------------------------------------------------------
    // Back part: the table itself, the compare-and-replace relaxation,
    // the improvement flag and the result register.
    // ------------------------------------------------------------------
    dvru_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_op    (pop_op),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .own_id    (own_id_reg),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

@@ rtl/dvru_checker.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route update - port checker
// Watches the result channel for run ordering and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_vector_route_update_assert.svh"

module dvru_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [dvru_pkg::NODE_W-1:0] out_dest,
    input logic [dvru_pkg::COST_W-1:0] out_cost,
    input logic [dvru_pkg::NODE_W-1:0] out_hop,
    input logic                        table_changed,
    input logic                        out_last
);
    import dvru_pkg::*;

    // A stalled result keeps its contents.
    `DVRU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_dest) && $stable(out_cost) && $stable(out_hop) && $stable(out_last))

    // Reads and unchanged results are single-beat runs.
    `DVRU_ASSERT_SAME(a_single_last, clk, rst_n, out_valid && !table_changed, out_last)

    // A table run continues without a gap until its last beat.
    `DVRU_ASSERT_NEXT(a_run_cont, clk, rst_n, out_valid && out_ready && table_changed && !out_last, out_valid && table_changed)

    // Destinations of a table run count upward one by one.
    `DVRU_ASSERT_NEXT(a_run_order, clk, rst_n, out_valid && out_ready && table_changed && !out_last, out_dest == $past(out_dest) + 1'b1)

endmodule

bind distance_vector_route_update dvru_checker u_dvru_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_dest      (out_ch.out_dest),
    .out_cost      (out_ch.out_cost),
    .out_hop       (out_ch.out_hop),
    .table_changed (out_ch.table_changed),
    .out_last      (out_ch.out_last)
);

`default_nettype wire
